/* hdl/c8x_pkg.sv */
// Package for the CHIP-8 execute core: controller states, command struct, constants.
// Used by c8x_ctrl, c8x_dpath and chip8_execute_core_top.
`default_nettype none
package c8x_pkg;
   localparam int STACK_DEPTH = 16;
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SI_W = $clog2(STACK_DEPTH);

   localparam logic [1:0] KIND_INSN = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_KEY  = 2'd2;

   localparam logic [11:0] FONT_RESET = 12'h050;
   localparam logic [11:0] PC_RESET   = 12'h200;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic exec;      // perform the item in the datapath
      logic emit;      // load the output register with the current result
   } cmd_type;

   typedef struct packed {
      logic [4:0] wr_count;  // number of stores of the item, 0 if none
   } status_type;
endpackage
`default_nettype wire

/* hdl/chip8_execute_core_top.sv */
// CHIP-8 execute core. An item is accepted in ST_IDLE and executed into the datapath
// registers; its results are then loaded into the single output register in ST_EMIT,
// one store result per cycle for FX33 and FX55 while the output is not stalled.
// One item is in work at a time. Reset (synchronous, active high) clears registers,
// timers, keys and the stack pointer, sets the PC to 0x200 and font_base to 0x50.
`default_nettype none
module chip8_execute_core_top
   import c8x_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // instruction[15:0], random_byte[23:16], key_index[27:24], key_pressed[28],
   // zero fill [31:29]
   input  wire logic [31:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_data,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_pc[11:0], mem_write[12], mem_address[24:13], mem_data[32:25],
   // clear_screen[33], sound_on[34], waiting_key[35], stack_error[36], zero [39:37]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);
   cmd_type    cmd;
   status_type status;
   logic [3:0] wr_index;
   logic [11:0] next_pc, mem_address;
   logic [7:0] mem_data;
   logic mem_write, clear_screen, sound_on, waiting_key, stack_error;

   // Font base register is always writable; user must write it only while idle.
   assign csr_ready = 1'b1;

   c8x_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .rsp_last(rsp_tlast), .wr_index, .status, .cmd
   );

   c8x_dpath u_dpath (
      .clock, .reset, .cmd, .status, .wr_index,
      .kind(req_tuser), .instruction(req_tdata[15:0]),
      .random_byte(req_tdata[23:16]), .key_index(req_tdata[27:24]),
      .key_pressed(req_tdata[28]),
      .csr_wr(csr_valid), .csr_data,
      .next_pc, .mem_write, .mem_address, .mem_data,
      .clear_screen, .sound_on, .waiting_key, .stack_error
   );

   assign rsp_tdata = {3'd0, stack_error, waiting_key, sound_on, clear_screen,
                       mem_data, mem_address, mem_write, next_pc};
endmodule
`default_nettype wire

/* hdl/c8x_ctrl.sv */
// Controller state machine of the CHIP-8 execute core.
// Depends on c8x_pkg; drives the datapath through cmd_type.
`default_nettype none
module c8x_ctrl
   import c8x_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic            rsp_last,
   output logic [3:0]      wr_index,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic vld_ff, vld_in, last_ff, last_in;
   logic space;

   assign space = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_last = last_ff;
   assign wr_index = cnt_ff[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff && !rsp_tready;
      last_in = last_ff;
      req_tready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               cnt_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (space) begin
               cmd.emit = 1'b1;
               vld_in = 1'b1;
               if (status.wr_count == 5'd0 || cnt_ff + 5'd1 >= status.wr_count) begin
                  last_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  last_in = 1'b0;
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* hdl/c8x_dpath.sv */
// Datapath of the CHIP-8 execute core: register file, stack, timers, keys, stores.
// Depends on c8x_pkg; commanded by c8x_ctrl.
`default_nettype none
module c8x_dpath
   import c8x_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [3:0]  wr_index,
   input  wire logic [1:0]  kind,
   input  wire logic [15:0] instruction,
   input  wire logic [7:0]  random_byte,
   input  wire logic [3:0]  key_index,
   input  wire logic        key_pressed,
   input  wire logic        csr_wr,
   input  wire logic [11:0] csr_data,
   output logic [11:0]      next_pc,
   output logic             mem_write,
   output logic [11:0]      mem_address,
   output logic [7:0]       mem_data,
   output logic             clear_screen,
   output logic             sound_on,
   output logic             waiting_key,
   output logic             stack_error
);
   logic [7:0]  regs_ff [16];
   logic [7:0]  regs_in [16];
   logic [11:0] stack_mem [STACK_DEPTH];
   logic [11:0] idx_ff, idx_in, pc_ff, pc_in, font_ff;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]  dly_ff, dly_in, snd_ff, snd_in;
   logic [15:0] keys_ff, keys_in;
   logic        wait_ff, wait_in;
   logic [3:0]  wtgt_ff, wtgt_in;
   logic        clr_ff, clr_in, serr_ff, serr_in;
   logic [4:0]  wcnt_ff, wcnt_in;
   logic [1:0]  mode_ff, mode_in;     // 1 BCD, 2 register dump
   logic [7:0]  bcd_ff [3];
   logic [7:0]  bcd_in [3];
   logic        push;
   logic [11:0] push_val;
   logic [11:0] sout;

   logic [3:0] x, y;
   logic [7:0] nn, v, vy, d;
   logic [11:0] nnn, pc2, pc4;
   logic [8:0] sum;
   logic [7:0] rem, tens;
   logic [15:0] prod;

   assign x = instruction[11:8];
   assign y = instruction[7:4];
   assign nn = instruction[7:0];
   assign nnn = instruction[11:0];
   assign v = regs_ff[x];
   assign vy = regs_ff[y];
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;
   assign sout = stack_mem[SI_W'(sp_ff - SP_W'(1))];

   always_ff @(posedge clock) begin
      if (push) stack_mem[sp_ff[SI_W-1:0]] <= push_val;
   end

   always_comb begin
      for (int i = 0; i < 16; i++) regs_in[i] = regs_ff[i];
      idx_in = idx_ff; pc_in = pc_ff; sp_in = sp_ff; dly_in = dly_ff; snd_in = snd_ff;
      keys_in = keys_ff; wait_in = wait_ff; wtgt_in = wtgt_ff;
      clr_in = clr_ff; serr_in = serr_ff; wcnt_in = wcnt_ff; mode_in = mode_ff;
      for (int i = 0; i < 3; i++) bcd_in[i] = bcd_ff[i];
      push = 1'b0; push_val = pc2; sum = '0; d = '0;
      rem = '0; tens = '0; prod = '0;
      if (cmd.exec) begin
         clr_in = 1'b0; serr_in = 1'b0; wcnt_in = '0; mode_in = 2'd0;
         if (kind == KIND_INSN && !wait_ff) begin
            pc_in = pc2;
            case (instruction[15:12])
               4'h0: begin
                  if (instruction == 16'h00E0) clr_in = 1'b1;
                  else if (instruction == 16'h00EE) begin
                     if (sp_ff == '0) serr_in = 1'b1;
                     else begin
                        sp_in = sp_ff - SP_W'(1);
                        pc_in = sout;
                     end
                  end
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) serr_in = 1'b1;
                  else begin
                     push = 1'b1;
                     sp_in = sp_ff + SP_W'(1);
                     pc_in = nnn;
                  end
               end
               4'h3: if (v == nn) pc_in = pc4;
               4'h4: if (v != nn) pc_in = pc4;
               4'h5: if (v == vy) pc_in = pc4;
               4'h6: regs_in[x] = nn;
               4'h7: regs_in[x] = v + nn;
               4'h8: begin
                  case (instruction[3:0])
                     4'h0: regs_in[x] = vy;
                     4'h1: regs_in[x] = v | vy;
                     4'h2: regs_in[x] = v & vy;
                     4'h3: regs_in[x] = v ^ vy;
                     4'h4: begin
                        sum = {1'b0, v} + {1'b0, vy};
                        regs_in[x] = sum[7:0];
                        regs_in[15] = {7'd0, sum[8]};
                     end
                     4'h5: begin
                        regs_in[x] = v - vy;
                        regs_in[15] = {7'd0, v >= vy};
                     end
                     4'h6: begin
                        regs_in[x] = {1'b0, v[7:1]};
                        regs_in[15] = {7'd0, v[0]};
                     end
                     4'h7: begin
                        regs_in[x] = vy - v;
                        regs_in[15] = {7'd0, vy >= v};
                     end
                     4'hE: begin
                        regs_in[x] = {v[6:0], 1'b0};
                        regs_in[15] = {7'd0, v[7]};
                     end
                     default: ;
                  endcase
               end
               4'h9: if (v != vy) pc_in = pc4;
               4'hA: idx_in = nnn;
               4'hB: pc_in = {4'd0, regs_ff[0]} + nnn;
               4'hC: regs_in[x] = random_byte & nn;
               4'hE: begin
                  if (nn == 8'h9E && keys_ff[v[3:0]]) pc_in = pc4;
                  else if (nn == 8'hA1 && !keys_ff[v[3:0]]) pc_in = pc4;
               end
               4'hF: begin
                  case (nn)
                     8'h07: regs_in[x] = dly_ff;
                     8'h0A: begin
                        wait_in = 1'b1; wtgt_in = x; pc_in = pc_ff;
                     end
                     8'h15: dly_in = v;
                     8'h18: snd_in = v;
                     8'h1E: idx_in = idx_ff + {4'd0, v};
                     8'h29: idx_in = font_ff + {4'd0, v} + {2'd0, v, 2'd0};
                     8'h33: begin
                        wcnt_in = 5'd3; mode_in = 2'd1;
                        d = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
                        rem = v - d * 8'd100;
                        // Tens digit by reciprocal multiplication, exact for 0..99.
                        prod = {8'd0, rem} * 16'd205;
                        tens = {3'd0, prod[15:11]};
                        bcd_in[0] = d;
                        bcd_in[1] = tens;
                        bcd_in[2] = rem - {tens[4:0], 3'd0} - {tens[6:0], 1'b0};
                     end
                     8'h55: begin
                        wcnt_in = {1'b0, x} + 5'd1; mode_in = 2'd2;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end else if (kind == KIND_TICK) begin
            if (dly_ff != 8'd0) dly_in = dly_ff - 8'd1;
            if (snd_ff != 8'd0) snd_in = snd_ff - 8'd1;
         end else if (kind == KIND_KEY) begin
            keys_in[key_index] = key_pressed;
            if (wait_ff && key_pressed) begin
               regs_in[wtgt_ff] = {4'd0, key_index};
               wait_in = 1'b0;
               pc_in = pc2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
         idx_ff <= '0; pc_ff <= PC_RESET; sp_ff <= '0; dly_ff <= '0; snd_ff <= '0;
         keys_ff <= '0; wait_ff <= 1'b0; wtgt_ff <= '0; font_ff <= FONT_RESET;
         clr_ff <= 1'b0; serr_ff <= 1'b0; wcnt_ff <= '0; mode_ff <= 2'd0;
      end else begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= regs_in[i];
         idx_ff <= idx_in; pc_ff <= pc_in; sp_ff <= sp_in; dly_ff <= dly_in;
         snd_ff <= snd_in; keys_ff <= keys_in; wait_ff <= wait_in; wtgt_ff <= wtgt_in;
         clr_ff <= clr_in; serr_ff <= serr_in; wcnt_ff <= wcnt_in; mode_ff <= mode_in;
         if (csr_wr) font_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) bcd_ff[i] <= bcd_in[i];
   end

   assign status.wr_count = wcnt_ff;

   // Output register, loaded once per result.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         next_pc <= pc_ff;
         clear_screen <= clr_ff;
         sound_on <= snd_ff != 8'd0;
         waiting_key <= wait_ff;
         stack_error <= serr_ff;
         mem_write <= wcnt_ff != 5'd0;
         mem_address <= (wcnt_ff != 5'd0) ? idx_ff + {8'd0, wr_index} : 12'd0;
         if (mode_ff == 2'd1) mem_data <= bcd_ff[wr_index[1:0]];
         else if (mode_ff == 2'd2) mem_data <= regs_ff[wr_index];
         else mem_data <= '0;
      end
   end
endmodule
`default_nettype wire
